>>> src/bscf_pkg.sv
// Shared constants and types for the bitmap set / clear / find block.
package bscf_pkg;

  // Field widths of the request and result items.
  localparam int unsigned ModeW  = 3;
  localparam int unsigned IndexW = 13;
  localparam int unsigned PosW   = 13;
  localparam int unsigned MaxW   = 12;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  // Reset value of the max_index register.
  localparam logic [MaxW-1:0] MaxIndexReset = 12'd4095;

  // Request modes; codes five to seven are undefined and do nothing.
  localparam logic [ModeW-1:0] ModeSet      = 3'd0;
  localparam logic [ModeW-1:0] ModeClear    = 3'd1;
  localparam logic [ModeW-1:0] ModeTest     = 3'd2;
  localparam logic [ModeW-1:0] ModeFindLow  = 3'd3;
  localparam logic [ModeW-1:0] ModeFindHigh = 3'd4;

  // Search direction of a priority encoder.
  typedef enum logic {
    DirLow  = 1'b0,
    DirHigh = 1'b1
  } dir_e;

endpackage

>>> src/bscf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module bscf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bscf_prio.sv
// Priority encoder that finds the lowest or the highest set bit of a vector.
module bscf_prio #(
  parameter int unsigned N = 128
) (
  input  logic [N-1:0]                      vec_i,
  input  bscf_pkg::dir_e                    dir_i,
  output logic                              found_o,
  output logic [((N > 1) ? $clog2(N) : 1)-1:0] idx_o
);
  import bscf_pkg::*;

  localparam int unsigned IdxW = (N > 1) ? $clog2(N) : 1;

  always_comb begin
    idx_o   = '0;
    found_o = |vec_i;
    if (dir_i == DirLow) begin
      // Walk downward so that the lowest hit is written last.
      for (int i = N - 1; i >= 0; i--) begin
        if (vec_i[i]) begin
          idx_o = IdxW'(i);
        end
      end
    end else begin
      for (int i = 0; i < N; i++) begin
        if (vec_i[i]) begin
          idx_o = IdxW'(i);
        end
      end
    end
  end

endmodule

>>> src/bitmap_set_clear_find.sv
// Bitmap with set, clear, test and find-lowest / find-highest-set requests.
//
// The block keeps a bitmap of BITS flags in a RAM of WORD_BITS-bit words,
// with one nonempty flag per word held in flip-flops that reset clears at
// once; a word whose flag is clear reads as zero, so the bitmap is empty
// right after reset and no clearing pass is needed. Each request item on
// the slave stream yields exactly one result item on the master stream.
// Set, clear, test and undefined requests read the word from the registered
// RAM port when accepted; set and clear write it back modified in StRmw once
// the output is free. Finds use StFind, where a priority encoder over the
// nonempty flags picks the word to read, and StFinish, where a second
// encoder picks the bit in it. A new item is taken as soon as the previous
// one has reached the output register, even while that result still waits to
// be taken. An index above max_index or not below BITS leaves the bitmap
// unchanged; set and clear then report status 1 and test reads 0. The find
// modes scan words 0 up to max_index / WORD_BITS and return the 1-based
// position, or 0 when none of the scanned bits is set. The max_index
// register is written through the cfg channel, which is always ready; the
// user must write it only while the block is idle; this is not enforced.
module bitmap_set_clear_find #(
  parameter int unsigned BITS      = 4096,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel for max_index.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bscf_pkg::MaxW-1:0]       cfg_data_i,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Bits from lowest: mode [2:0], index [15:3].
  input  logic [bscf_pkg::InDataW-1:0]    s_axis_tdata,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Bits from lowest: status [0], bit_value [1], position [14:2], zero [15].
  output logic [bscf_pkg::OutDataW-1:0]   m_axis_tdata
);
  import bscf_pkg::*;

  localparam int unsigned NWords = (BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AddrW  = (NWords > 1) ? $clog2(NWords) : 1;
  localparam int unsigned BitW   = $clog2(WORD_BITS);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StRmw    = 4'b0010,
    StFind   = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [ModeW-1:0]  mode_q;
  logic [IndexW-1:0] index_q;
  logic [AddrW-1:0]  addr_q;
  logic              hit_q;
  logic [MaxW-1:0]   max_q;
  logic [NWords-1:0] nonempty_q;

  logic              out_valid_q;
  logic              status_q;
  logic              bitv_q;
  logic [PosW-1:0]   pos_q;

  // Request fields and handshakes.
  logic [ModeW-1:0]  in_mode;
  logic [IndexW-1:0] in_index;
  logic              in_fire;
  logic              out_free;

  assign in_mode  = s_axis_tdata[ModeW-1:0];
  assign in_index = s_axis_tdata[ModeW +: IndexW];

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Word address of the incoming index; only used when the index is in range.
  logic [AddrW-1:0] in_addr;
  assign in_addr = AddrW'(32'(in_index) / WORD_BITS);

  // Scan limit of the find modes, from the max_index register.
  logic [MaxW-1:0]   last_word;
  logic [NWords-1:0] scan_mask;
  dir_e              find_dir;

  assign last_word = MaxW'(32'(max_q) / WORD_BITS);
  assign find_dir  = (mode_q == ModeFindHigh) ? DirHigh : DirLow;

  always_comb begin
    for (int w = 0; w < NWords; w++) begin
      scan_mask[w] = (32'(w) <= 32'(last_word));
    end
  end

  // Word-level encoder over the scanned nonempty flags.
  logic             word_found;
  logic [AddrW-1:0] word_idx;

  bscf_prio #(
    .N (NWords)
  ) u_word_prio (
    .vec_i   (nonempty_q & scan_mask),
    .dir_i   (find_dir),
    .found_o (word_found),
    .idx_o   (word_idx)
  );

  // Word RAM.
  logic                 ram_we;
  logic                 ram_re;
  logic [AddrW-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] ram_wdata;

  assign ram_re    = in_fire || (state_q == StFind);
  assign ram_raddr = (state_q == StFind) ? word_idx : in_addr;

  bscf_ram #(
    .Width (WORD_BITS),
    .Depth (NWords)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The stored word as the bitmap sees it: a word never marked nonempty is zero.
  logic [WORD_BITS-1:0] cur_word;
  assign cur_word = nonempty_q[addr_q] ? ram_rdata : '0;

  // Read-modify-write path for set, clear and test.
  logic                 in_range;
  logic                 is_set;
  logic                 is_clear;
  logic                 is_test;
  logic [BitW-1:0]      bit_sel;
  logic [WORD_BITS-1:0] bit_mask;

  assign in_range  = ({1'b0, max_q} >= index_q) && (32'(index_q) < BITS);
  assign is_set    = (mode_q == ModeSet);
  assign is_clear  = (mode_q == ModeClear);
  assign is_test   = (mode_q == ModeTest);
  assign bit_sel   = BitW'(32'(index_q) % WORD_BITS);
  assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel;
  assign ram_wdata = is_set ? (cur_word | bit_mask) : (cur_word & ~bit_mask);
  assign ram_we    = (state_q == StRmw) && out_free && in_range && (is_set || is_clear);

  // Bit-level encoder within the word that the find selected.
  logic            bit_found;
  logic [BitW-1:0] bit_idx;
  logic [31:0]     pos_full;

  bscf_prio #(
    .N (WORD_BITS)
  ) u_bit_prio (
    .vec_i   (cur_word),
    .dir_i   (find_dir),
    .found_o (bit_found),
    .idx_o   (bit_idx)
  );

  assign pos_full = 32'(addr_q) * 32'(WORD_BITS) + 32'(bit_idx) + 32'd1;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (in_mode == ModeFindLow || in_mode == ModeFindHigh) begin
            state_d = StFind;
          end else begin
            state_d = StRmw;
          end
        end
      end
      StRmw: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      StFind: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      max_q       <= MaxIndexReset;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_q <= cfg_data_i;
      end
      if (ram_we) begin
        nonempty_q[addr_q] <= |ram_wdata;
      end
      if (((state_q == StRmw) || (state_q == StFinish)) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= in_mode;
      index_q <= in_index;
      addr_q  <= in_addr;
    end
    if (state_q == StFind) begin
      addr_q <= word_idx;
      hit_q  <= word_found;
    end
    if ((state_q == StRmw) && out_free) begin
      status_q <= (is_set || is_clear) && !in_range;
      bitv_q   <= is_test && in_range && |(cur_word & bit_mask);
      pos_q    <= '0;
    end
    if ((state_q == StFinish) && out_free) begin
      status_q <= 1'b0;
      bitv_q   <= 1'b0;
      pos_q    <= (hit_q && bit_found) ? pos_full[PosW-1:0] : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, pos_q, bitv_q, status_q};

endmodule

>>> tb/bitmap_flag_checker.sv
// Checker for the bitmap block: tracks the flag store and compares every result item.
`timescale 1ns / 1ps

module bitmap_flag_checker #(
  parameter int unsigned BITS      = 4096,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bscf_pkg::MaxW-1:0]     cfg_data_i,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  // Bits from lowest: mode [2:0], index [15:3].
  input  logic [bscf_pkg::InDataW-1:0]  req_data_i,
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  // Bits from lowest: status [0], bit_value [1], position [14:2], zero [15].
  input  logic [bscf_pkg::OutDataW-1:0] res_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import bscf_pkg::*;

  localparam int unsigned NumWords = (BITS + WORD_BITS - 1) / WORD_BITS;

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [ModeW-1:0]  mode;
  } request_t;

  typedef struct packed {
    logic            pad;
    logic [PosW-1:0] position;
    logic            bit_value;
    logic            status;
  } result_t;

  logic [WORD_BITS-1:0] flag_words [NumWords];
  logic [MaxW-1:0]      max_index_q;
  result_t              expected_results [$];

  task automatic report_mismatch(input string what, input logic [OutDataW-1:0] want_v,
                                 input logic [OutDataW-1:0] got_v);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t ns: mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
    end
  endtask

  // Applies one request to the tracked bitmap and works out its result item.
  task automatic predict_bitmap_op(input request_t req, output result_t res);
    int unsigned scan_words;
    int unsigned word_sel;
    int unsigned bit_sel;
    logic        found;
    res        = '0;
    found      = 1'b0;
    scan_words = max_index_q / WORD_BITS + 1;
    if (scan_words > NumWords) begin
      scan_words = NumWords;
    end
    case (req.mode)
      ModeSet, ModeClear, ModeTest: begin
        if (req.index <= max_index_q && req.index < BITS) begin
          word_sel = req.index / WORD_BITS;
          bit_sel  = req.index % WORD_BITS;
          if (req.mode == ModeSet) begin
            flag_words[word_sel][bit_sel] = 1'b1;
          end else if (req.mode == ModeClear) begin
            flag_words[word_sel][bit_sel] = 1'b0;
          end else begin
            res.bit_value = flag_words[word_sel][bit_sel];
          end
        end else if (req.mode != ModeTest) begin
          res.status = 1'b1;
        end
      end
      ModeFindLow: begin
        for (int w = 0; w < int'(scan_words); w++) begin
          for (int b = 0; b < int'(WORD_BITS); b++) begin
            if (!found && flag_words[w][b]) begin
              found        = 1'b1;
              res.position = PosW'(w * WORD_BITS + b + 1);
            end
          end
        end
      end
      ModeFindHigh: begin
        for (int w = int'(scan_words) - 1; w >= 0; w--) begin
          for (int b = int'(WORD_BITS) - 1; b >= 0; b--) begin
            if (!found && flag_words[w][b]) begin
              found        = 1'b1;
              res.position = PosW'(w * WORD_BITS + b + 1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      for (int w = 0; w < int'(NumWords); w++) begin
        flag_words[w] = '0;
      end
      max_index_q = MaxIndexReset;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // Results leave before a request accepted at the same edge is predicted.
      if (res_valid_i && res_ready_i) begin
        got = result_t'(res_data_i);
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            report_mismatch("status", OutDataW'(want.status), OutDataW'(got.status));
          end
          if (got.bit_value !== want.bit_value) begin
            report_mismatch("bit_value", OutDataW'(want.bit_value), OutDataW'(got.bit_value));
          end
          if (got.position !== want.position) begin
            report_mismatch("position", OutDataW'(want.position), OutDataW'(got.position));
          end
          if (got.pad !== 1'b0) begin
            report_mismatch("padding bit", '0, OutDataW'(got.pad));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        max_index_q = cfg_data_i;
      end
      if (req_valid_i && req_ready_i) begin
        predict_bitmap_op(request_t'(req_data_i), want);
        expected_results.push_back(want);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

>>> tb/tb_bitmap_set_clear_find.sv
// Testbench top for the bitmap set / clear / find block: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_bitmap_set_clear_find;
  import bscf_pkg::*;

  // Codes above the find modes are undefined; the block must treat them as no-ops.
  localparam logic [ModeW-1:0] ModeUndefFirst = 3'd5;
  localparam logic [ModeW-1:0] ModeUndefMid   = 3'd6;
  localparam logic [ModeW-1:0] ModeUndefLast  = 3'd7;

  // Time given after the last result is back, so that the block can settle
  // into idle before the next step of the test.
  localparam int unsigned SettleCycles   = 6;
  // The receiver stops taking results for a long stretch once, after this many.
  localparam int unsigned HoldOffAfter   = 350;
  localparam int unsigned HoldOffCycles  = 500;
  localparam int unsigned ItemsPerPhase  = 120;
  localparam int unsigned NumPhases      = 9;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [MaxW-1:0]       cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // Bits from lowest: mode [2:0], index [15:3].
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // Bits from lowest: status [0], bit_value [1], position [14:2], zero [15].
  logic [OutDataW-1:0]   m_axis_tdata;
  int unsigned           fail_count;
  int unsigned           pending;

  // Stimulus-side view of the configured limit, used only to aim the indices.
  logic [MaxW-1:0]       cur_max;
  int unsigned           sent;

  always #1 clk_i = ~clk_i;

  bitmap_set_clear_find uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bitmap_flag_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Idle gaps: mostly none or short, now and then a long one. During a quiet
  // stretch there are no gaps at all, so back-to-back traffic is covered too.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Sets slightly outnumber clears so the bitmap neither fills nor empties,
  // and the finds see a changing mix of answers.
  function automatic logic [ModeW-1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 32) begin
      return ModeSet;
    end else if (r < 54) begin
      return ModeClear;
    end else if (r < 72) begin
      return ModeTest;
    end else if (r < 82) begin
      return ModeFindLow;
    end else if (r < 92) begin
      return ModeFindHigh;
    end
    return ModeW'($urandom_range(ModeUndefFirst, ModeUndefLast));
  endfunction

  // Indices fall anywhere up to the limit, or cluster in a low window and just
  // under it, so that set, clear and test hit the same words and the finds land at
  // both ends. The rest probes the limit itself and the whole 13-bit field.
  function automatic logic [IndexW-1:0] pick_index(input logic [MaxW-1:0] limit);
    int unsigned r;
    int unsigned span;
    r    = $urandom_range(0, 99);
    span = (limit < 95) ? limit : 95;
    if (r < 40) begin
      return IndexW'($urandom_range(0, limit));
    end else if (r < 60) begin
      return IndexW'($urandom_range(0, span));
    end else if (r < 75) begin
      return IndexW'(limit - $urandom_range(0, span));
    end else if (r < 85) begin
      return IndexW'(limit + $urandom_range(0, 1));
    end
    return IndexW'($urandom_range(0, (1 << IndexW) - 1));
  endfunction

  // Offers one request and holds it until the block takes it, then maybe
  // idles. The valid stays high into the next request when there is no gap.
  task automatic send_request(input logic [ModeW-1:0] mode, input logic [IndexW-1:0] index);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {index, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    gap = pick_gap(((sent / 50) % 4) == 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until every predicted result has come back and the block is idle.
  // The count is read on the falling edge, away from the checker's updates.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes max_index; called only while the block is idle.
  task automatic write_max_index(input logic [MaxW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_max = value;
  endtask

  // Result side: takes results with random stalls, and once holds off for a
  // long stretch while the sender keeps offering, so the block backs up.
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    taken         = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
      if (taken == HoldOffAfter) begin
        gap = HoldOffCycles;
      end else begin
        gap = pick_gap(((taken / 60) % 4) == 1);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [MaxW-1:0] phase_max [NumPhases];
    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cur_max       = MaxIndexReset;
    sent          = 0;
    // Limits for the random phases: both extremes, word edges and a few others.
    phase_max = '{12'd0, 12'd31, 12'd32, 12'd4095, 12'd63, 12'd0, 12'd4064, 12'd1000, 12'd4095};
    phase_max[5] = MaxW'($urandom_range(0, (1 << MaxW) - 1));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset limit. First the empty bitmap: test and both
    // finds must all read zero.
    send_request(ModeTest, 13'd0);
    send_request(ModeFindLow, 13'd0);
    send_request(ModeFindHigh, 13'd0);
    // Both ends of the bitmap, plus the top bit of a word, which the
    // highest-set search must not skip.
    send_request(ModeSet, 13'd0);
    send_request(ModeSet, 13'd4095);
    send_request(ModeSet, 13'd31);
    send_request(ModeSet, 13'd63);
    send_request(ModeFindLow, 13'd8191);
    send_request(ModeFindHigh, 13'd0);
    send_request(ModeTest, 13'd4095);
    // Out of range: set and clear report status, test reads zero.
    send_request(ModeSet, 13'd4096);
    send_request(ModeClear, 13'd8191);
    send_request(ModeTest, 13'd8191);
    // Undefined modes change nothing and return all zeros.
    send_request(ModeUndefFirst, 13'd8191);
    send_request(ModeUndefMid, 13'd0);
    send_request(ModeUndefLast, 13'd31);
    send_request(ModeClear, 13'd0);
    send_request(ModeFindLow, 13'd0);
    send_request(ModeClear, 13'd4095);
    send_request(ModeFindHigh, 13'd0);
    send_request(ModeTest, 13'd31);

    // Lowering the limit keeps bits already stored. Bit 63 is now above the
    // limit but still inside a scanned word, so the high find reports it.
    wait_for_drain();
    write_max_index(12'd40);
    send_request(ModeTest, 13'd63);
    send_request(ModeSet, 13'd41);
    send_request(ModeFindHigh, 13'd0);
    send_request(ModeClear, 13'd40);

    // Random phases, each under its own limit.
    for (int p = 0; p < int'(NumPhases); p++) begin
      wait_for_drain();
      write_max_index(phase_max[p]);
      for (int i = 0; i < int'(ItemsPerPhase); i++) begin
        send_request(pick_mode(), pick_index(cur_max));
      end
    end

    wait_for_drain();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
